/* design/hlbc_pkg.sv */
package hlbc_pkg;

  // Field widths fixed by the interface
  localparam int RHO_W     = 18;
  localparam int THETA_W   = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_W     = 12;
  localparam int FOUND_W   = 2;

  // Datapath widths
  localparam int TRIG_W = 16;  // signed Q2.14
  localparam int NUM_W  = 29;  // signed numerator
  localparam int MAG_W  = 28;  // numerator magnitude
  localparam int DIV_W  = 15;  // divisor magnitude, up to 16384

  localparam int THETA_STEPS_DEF = 180;
  localparam int COORD_BITS_DEF  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

  localparam logic [FOUND_W-1:0] FOUND_BOTH  = 2'd0;
  localparam logic [FOUND_W-1:0] FOUND_START = 2'd1;
  localparam logic [FOUND_W-1:0] FOUND_NONE  = 2'd2;

  typedef struct packed {
    logic signed [RHO_W-1:0] rho;
    logic [THETA_W-1:0]      theta_index;
  } line_t;

  typedef struct packed {
    logic [OUT_W-1:0]   start_x;
    logic [OUT_W-1:0]   start_y;
    logic [OUT_W-1:0]   end_x;
    logic [OUT_W-1:0]   end_y;
    logic [FOUND_W-1:0] found;
  } clip_t;

  // Per-item flags that ride along with the divider lanes
  typedef struct packed {
    logic [3:0] neg;     // quotient negative
    logic [3:0] sat;     // quotient magnitude beyond the coordinate range
    logic       cos_zero;
    logic       sin_zero;
  } side_t;

endpackage

/* design/hlbc_div_stage.sv */
module hlbc_div_stage #(
  parameter int NS    = 13,
  parameter int BASE  = 12,
  parameter int STEPS = 4
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hlbc_pkg::MAG_W-1:0] rem_in,
  input  logic [NS-1:0]              q_in,
  input  logic [hlbc_pkg::DIV_W-1:0] d_in,
  output logic [hlbc_pkg::MAG_W-1:0] rem,
  output logic [NS-1:0]              q,
  output logic [hlbc_pkg::DIV_W-1:0] d
);
  import hlbc_pkg::*;

  localparam int CMPW = (MAG_W > DIV_W + NS) ? MAG_W : DIV_W + NS;

  logic [CMPW-1:0]  r_w;
  logic [CMPW-1:0]  sh_w;
  logic [NS-1:0]    q_w;

  // restoring steps, most significant quotient bit first
  always_comb begin
    r_w  = CMPW'(rem_in);
    q_w  = q_in;
    sh_w = '0;
    for (int j = 0; j < STEPS; j++) begin
      sh_w = CMPW'(d_in) << (BASE - j);
      if (r_w >= sh_w) begin
        r_w            = r_w - sh_w;
        q_w[BASE - j]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= MAG_W'(r_w);
      q   <= q_w;
      d   <= d_in;
    end
  end

endmodule

/* design/hough_line_border_clip.sv */
// Hough line border clip: turns one (rho, theta_index) line into the two
// points where it crosses the image border [0..W]x[0..H].
// Channels: in_valid/in_ready carry one line item (rho signed Q14.4,
// theta_index meaning k*pi/THETA_STEPS). out_valid/out_ready carry one
// result item per line: start and end points plus a found code (both,
// start only, none); missing points read as zero.
// cfg_valid/cfg_ready write the image width (index 0) or the image height
// (index 1); cfg_ready is always high. Write only while the block is idle.
// Throughput: one item per cycle while the receiver keeps out_ready high.
// The four border quotients run in four parallel restoring dividers,
// up to four quotient bits per stage.
// Every stage has its own valid bit and a stage moves when the one after
// it is empty or moving, so a stalled receiver fills bubbles first and
// only then drops in_ready. Nothing is lost or repeated under stall.
// Reset (rst, synchronous) empties the pipeline and sets W=640, H=480.
module hough_line_border_clip #(
  parameter int THETA_STEPS = hlbc_pkg::THETA_STEPS_DEF,
  parameter int COORD_BITS  = hlbc_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hlbc_pkg::line_t                in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hlbc_pkg::clip_t                out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hlbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hlbc_pkg::CFG_W-1:0]     cfg_data
);
  import hlbc_pkg::*;

  // quotient bits: magnitude is clamped to 2^COORD_BITS
  localparam int NS    = COORD_BITS + 1;
  localparam int SPS   = 4;
  localparam int ND    = (NS + SPS - 1) / SPS;
  localparam int S_DIV = 4;
  localparam int S_OUT = S_DIV + ND;
  localparam int NST   = S_OUT + 1;
  localparam int XW    = (COORD_BITS + 2 > CFG_W + 1) ? COORD_BITS + 2 : CFG_W + 1;
  localparam int SATW  = ((MAG_W > DIV_W + NS) ? MAG_W : DIV_W + NS) + 1;
  localparam int TAB_N = 1 << THETA_W;
  localparam int TWO_N = 2 * THETA_STEPS;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1 << 30;
  localparam logic [NS-1:0]   LIM     = NS'(1) << COORD_BITS;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [0:TAB_N-1];

  // ---------------- sine / cosine table, built at elaboration ----------
  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > ONE_Q30) return ONE_Q30;
    return v;
  endfunction

  // returns {sin, cos} in Q2.14 for angle index k
  function automatic logic [2*TRIG_W-1:0] angle_sc(int kin);
    longint unsigned k, a, x2, ts, tc;
    longint          ss, sc, qs, qc;
    logic            neg, mir;
    k   = longint'(kin % TWO_N);
    neg = 1'b0;
    mir = 1'b0;
    if (k >= THETA_STEPS) begin
      k   = k - THETA_STEPS;
      neg = 1'b1;
    end
    if (2 * k > THETA_STEPS) begin
      k   = THETA_STEPS - k;
      mir = 1'b1;
    end
    a  = (k * PI_Q30) / THETA_STEPS;
    x2 = (a * a) >> 30;
    ts = a;
    tc = 64'd1 << 30;
    ss = longint'(a);
    sc = ONE_Q30;
    ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;
    ss -= longint'(ts);           sc -= longint'(tc);
    ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;
    ss += longint'(ts);           sc += longint'(tc);
    ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;
    ss -= longint'(ts);           sc -= longint'(tc);
    ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;
    ss += longint'(ts);           sc += longint'(tc);
    ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;
    ss -= longint'(ts);           sc -= longint'(tc);
    ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132;
    ss += longint'(ts);           sc += longint'(tc);
    ts = ((ts * x2) >> 30) / 210; tc = ((tc * x2) >> 30) / 182;
    ss -= longint'(ts);           sc -= longint'(tc);
    ts = ((ts * x2) >> 30) / 272; tc = ((tc * x2) >> 30) / 240;
    ss += longint'(ts);           sc += longint'(tc);
    ts = ((ts * x2) >> 30) / 342; tc = ((tc * x2) >> 30) / 306;
    ss -= longint'(ts);           sc -= longint'(tc);
    ts = ((ts * x2) >> 30) / 420; tc = ((tc * x2) >> 30) / 380;
    ss += longint'(ts);           sc += longint'(tc);
    qs = (clamp_unit(ss) + (64'sd1 << 15)) >>> 16;
    qc = (clamp_unit(sc) + (64'sd1 << 15)) >>> 16;
    if (mir) qc = -qc;
    if (neg) begin
      qs = -qs;
      qc = -qc;
    end
    return {TRIG_W'(qs), TRIG_W'(qc)};
  endfunction

  function automatic trig_tab_t build_sin();
    trig_tab_t t;
    logic [2*TRIG_W-1:0] v;
    for (int k = 0; k < TAB_N; k++) begin
      v    = angle_sc(k);
      t[k] = v[2*TRIG_W-1:TRIG_W];
    end
    return t;
  endfunction

  function automatic trig_tab_t build_cos();
    trig_tab_t t;
    logic [2*TRIG_W-1:0] v;
    for (int k = 0; k < TAB_N; k++) begin
      v    = angle_sc(k);
      t[k] = v[TRIG_W-1:0];
    end
    return t;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sin();
  localparam trig_tab_t COS_TAB = build_cos();

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] img_width;
  logic [CFG_W-1:0] img_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= WIDTH_RST;
      img_height <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  img_width  <= cfg_data;
        CFG_HEIGHT: img_height <= cfg_data;
        default:    img_width  <= img_width;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // rdy[i]: stage i may load this cycle (empty, or its content moves on)
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  // ---------------- stage 0: input register ----------------
  line_t line0;

  always_ff @(posedge clk) begin
    if (rdy[0]) line0 <= in_data;
  end

  // ---------------- stage 1: table lookup, rho scaling ----------------
  logic signed [TRIG_W-1:0] s1, c1;
  logic signed [NUM_W-1:0]  num1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1   <= SIN_TAB[line0.theta_index];
      c1   <= COS_TAB[line0.theta_index];
      num1 <= NUM_W'(line0.rho) <<< 10;   // Q14.4 * 1024 -> Q14.14 scale
    end
  end

  // ---------------- stage 2: H*sin and W*cos ----------------
  logic signed [TRIG_W-1:0] s2, c2;
  logic signed [NUM_W-1:0]  num2, hs2, wc2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2   <= s1;
      c2   <= c1;
      num2 <= num1;
      hs2  <= $signed({1'b0, img_height}) * s1;
      wc2  <= $signed({1'b0, img_width}) * c1;
    end
  end

  // ---------------- stage 3: numerators, signs, range check ----------------
  logic signed [NUM_W-1:0] n3   [0:3];
  logic signed [TRIG_W-1:0] d3s [0:3];
  logic [MAG_W-1:0]        nmag3 [0:3];
  logic [DIV_W-1:0]        dmag3 [0:3];
  side_t                   side3;

  logic [MAG_W-1:0] rem3 [0:3];
  logic [DIV_W-1:0] dd3  [0:3];
  side_t            side [0:ND];

  always_comb begin
    n3[0]  = num2;          // top:    rho / cos
    n3[1]  = num2 - hs2;    // bottom: (rho - H sin) / cos
    n3[2]  = num2;          // left:   rho / sin
    n3[3]  = num2 - wc2;    // right:  (rho - W cos) / sin
    d3s[0] = c2;
    d3s[1] = c2;
    d3s[2] = s2;
    d3s[3] = s2;
    side3.cos_zero = (c2 == '0);
    side3.sin_zero = (s2 == '0);
    for (int l = 0; l < 4; l++) begin
      nmag3[l]      = MAG_W'(n3[l][NUM_W-1] ? -n3[l] : n3[l]);
      dmag3[l]      = DIV_W'(d3s[l][TRIG_W-1] ? -d3s[l] : d3s[l]);
      side3.neg[l]  = n3[l][NUM_W-1] ^ d3s[l][TRIG_W-1];
      side3.sat[l]  = SATW'(nmag3[l]) >= (SATW'(dmag3[l]) << NS);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rem3    <= nmag3;
      dd3     <= dmag3;
      side[0] <= side3;
    end
    for (int s = 0; s < ND; s++) begin
      if (rdy[S_DIV + s]) side[s+1] <= side[s];
    end
  end

  // ---------------- divider stages ----------------
  logic [MAG_W-1:0] drem [1:ND][0:3];
  logic [NS-1:0]    dq   [1:ND][0:3];
  logic [DIV_W-1:0] dd   [1:ND][0:3];

  for (genvar s = 0; s < ND; s++) begin : g_div
    localparam int BASE  = NS - 1 - s * SPS;
    localparam int STEPS = (NS - s * SPS < SPS) ? NS - s * SPS : SPS;
    for (genvar l = 0; l < 4; l++) begin : g_lane
      if (s == 0) begin : g_first
        hlbc_div_stage #(.NS(NS), .BASE(BASE), .STEPS(STEPS)) u_div (
          .clk    (clk),
          .en     (rdy[S_DIV + s]),
          .rem_in (rem3[l]),
          .q_in   ({NS{1'b0}}),
          .d_in   (dd3[l]),
          .rem    (drem[s+1][l]),
          .q      (dq[s+1][l]),
          .d      (dd[s+1][l])
        );
      end else begin : g_next
        hlbc_div_stage #(.NS(NS), .BASE(BASE), .STEPS(STEPS)) u_div (
          .clk    (clk),
          .en     (rdy[S_DIV + s]),
          .rem_in (drem[s][l]),
          .q_in   (dq[s][l]),
          .d_in   (dd[s][l]),
          .rem    (drem[s+1][l]),
          .q      (dq[s+1][l]),
          .d      (dd[s+1][l])
        );
      end
    end
  end

  // ---------------- output stage: clamp, inside test, pick points --------
  logic [NS-1:0]        qmag [0:3];
  logic signed [XW-1:0] qv   [0:3];
  logic signed [XW-1:0] px   [0:3];
  logic signed [XW-1:0] py   [0:3];
  logic signed [XW-1:0] wx, hx;
  logic [3:0]           ins;
  logic                 got_first, got_second;
  clip_t                res;

  always_comb begin
    wx = $signed(XW'(img_width));
    hx = $signed(XW'(img_height));
    for (int l = 0; l < 4; l++) begin
      if (side[ND].sat[l] || dq[ND][l] > LIM) qmag[l] = LIM;
      else qmag[l] = dq[ND][l];
      qv[l] = side[ND].neg[l] ? -$signed(XW'(qmag[l])) : $signed(XW'(qmag[l]));
    end
    // horizontal line (cos zero): top and bottom crossings both sit at x = W
    px[0] = side[ND].cos_zero ? wx : qv[0];
    py[0] = '0;
    px[1] = side[ND].cos_zero ? wx : qv[1];
    py[1] = hx;
    // vertical line (sin zero): left and right crossings both sit at y = H
    px[2] = '0;
    py[2] = side[ND].sin_zero ? hx : qv[2];
    px[3] = wx;
    py[3] = side[ND].sin_zero ? hx : qv[3];

    got_first  = 1'b0;
    got_second = 1'b0;
    res        = '0;
    for (int i = 0; i < 4; i++) begin
      ins[i] = (px[i] >= 0) && (px[i] <= wx) && (py[i] >= 0) && (py[i] <= hx);
      if (ins[i]) begin
        if (!got_first) begin
          got_first   = 1'b1;
          res.start_x = OUT_W'(px[i]);
          res.start_y = OUT_W'(py[i]);
        end else if (!got_second) begin
          got_second = 1'b1;
          res.end_x  = OUT_W'(px[i]);
          res.end_y  = OUT_W'(py[i]);
        end
      end
    end
    if (!got_first) res.found = FOUND_NONE;
    else if (!got_second) res.found = FOUND_START;
    else res.found = FOUND_BOTH;
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) out_data <= res;
  end

endmodule
